// ===== design/pqem_pkg.sv =====
// ----------------------------------------------------------------------------
// pqem_pkg
// Shared types and constants for the extract-max priority queue: request and
// response transaction structs, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package pqem_pkg;

  // Fixed field widths of the request and response transactions
  localparam int TAG_FIELD_BITS  = 32;
  localparam int PRIO_FIELD_BITS = 16;
  localparam int OCC_BITS        = 5;

  // Default sizes handed to the top-level parameters
  localparam int DEF_CAPACITY      = 16;
  localparam int DEF_TAG_BITS      = 32;
  localparam int DEF_PRIORITY_BITS = 16;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                        operation;
    logic [TAG_FIELD_BITS-1:0]  entry_tag;
    logic [PRIO_FIELD_BITS-1:0] entry_priority;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic [TAG_FIELD_BITS-1:0]  out_tag;
    logic [PRIO_FIELD_BITS-1:0] out_priority;
    logic [OCC_BITS-1:0]        occupancy;
  } rsp_t;

endpackage

// ===== design/pqem_ram.sv =====
// ----------------------------------------------------------------------------
// pqem_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module pqem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pqem_max_unit.sv =====
// ----------------------------------------------------------------------------
// pqem_max_unit
// Running-maximum tracker shared across the extract scan. One slot word is
// compared per cycle; strict greater-than keeps the oldest entry on ties.
// ----------------------------------------------------------------------------
module pqem_max_unit #(
  parameter int CNT_W         = 5,
  parameter int PRIORITY_BITS = 16,
  parameter int WORD_W        = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              sample,
  input  logic [CNT_W-1:0]  sample_idx,
  input  logic [WORD_W-1:0] sample_word,
  output logic [CNT_W-1:0]  best_idx,
  output logic [WORD_W-1:0] best_word
);

  logic first;
  logic take;

  // First sample of a scan always wins, later ones only when strictly larger
  always_comb begin
    take = sample && (first ||
           (sample_word[PRIORITY_BITS-1:0] > best_word[PRIORITY_BITS-1:0]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
    end else if (start) begin
      first <= 1'b1;
    end else if (sample) begin
      first <= 1'b0;
    end
    if (take) begin
      best_idx  <= sample_idx;
      best_word <= sample_word;
    end
  end

endmodule

// ===== design/priority_queue_extract_max.sv =====
// ----------------------------------------------------------------------------
// priority_queue_extract_max
// Bounded priority queue kept in arrival order, with insert and extract-max.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one operation per
//   transaction: insert a tag/priority pair, or extract the highest-priority
//   entry (oldest wins on equal priority). rsp channel (rsp_valid/rsp_ready/
//   rsp) returns exactly one response per request: status, extracted tag and
//   priority (zero unless an extract succeeded), and occupancy afterwards.
// Sequencing:
//   Insert, full insert and empty extract respond in the cycle after
//   acceptance. An extract scans the slot RAM through its single read
//   port and the shared compare unit, then entries behind the winner
//   are moved down one slot a cycle. One request is in flight at a
//   time; req_ready is low while an extract runs.
// Reset:
//   Synchronous rst empties the queue; slot RAM contents are not cleared.
// Stall:
//   The response register holds while rsp_ready is low; a new request is
//   taken only once the pending response is leaving or gone.
// ----------------------------------------------------------------------------
module priority_queue_extract_max #(
  parameter int CAPACITY      = pqem_pkg::DEF_CAPACITY,
  parameter int TAG_BITS      = pqem_pkg::DEF_TAG_BITS,
  parameter int PRIORITY_BITS = pqem_pkg::DEF_PRIORITY_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pqem_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output pqem_pkg::rsp_t rsp
);

  import pqem_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int WORD_W = TAG_BITS + PRIORITY_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   ptr;
  logic               pend;
  logic [CNT_W-1:0]   pend_idx;

  logic               slot_free;
  logic               accept;
  logic               start;
  logic               rsp_load;
  logic               sample;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W-1:0]   shift_dst;
  logic [CNT_W-1:0]   best_idx;
  logic [WORD_W-1:0]  best_word;
  logic [TAG_BITS+TAG_FIELD_BITS-1:0]       tag_in_ext;
  logic [PRIORITY_BITS+PRIO_FIELD_BITS-1:0] prio_in_ext;
  logic [TAG_FIELD_BITS+TAG_BITS-1:0]       tag_out_ext;
  logic [PRIO_FIELD_BITS+PRIORITY_BITS-1:0] prio_out_ext;
  logic [WORD_W-1:0]  new_word;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [WORD_W-1:0]  ram_wr_data;
  logic               ram_rd_en;
  logic [WORD_W-1:0]  ram_rd_data;

  // Count to occupancy field width, zero-extended or truncated
  function automatic logic [OCC_BITS-1:0] to_occ(input logic [CNT_W-1:0] c);
    logic [OCC_BITS+CNT_W-1:0] ext;
    ext = {{OCC_BITS{1'b0}}, c};
    return ext[OCC_BITS-1:0];
  endfunction

  // Width adaptation between transaction fields and stored words
  always_comb begin
    tag_in_ext   = {{TAG_BITS{1'b0}}, req.entry_tag};
    prio_in_ext  = {{PRIORITY_BITS{1'b0}}, req.entry_priority};
    new_word     = {tag_in_ext[TAG_BITS-1:0], prio_in_ext[PRIORITY_BITS-1:0]};
    tag_out_ext  = {{TAG_FIELD_BITS{1'b0}}, best_word[WORD_W-1:PRIORITY_BITS]};
    prio_out_ext = {{PRIO_FIELD_BITS{1'b0}}, best_word[PRIORITY_BITS-1:0]};
  end

  // Handshake and counters
  always_comb begin
    slot_free = !rsp_valid || rsp_ready;
    req_ready = (state == S_IDLE) && slot_free;
    accept    = req_valid && req_ready;
    start     = accept && (req.operation == OP_EXTRACT) && (cnt != '0);
    // response loads on an insert or empty extract at acceptance, or at the end of an extract
    rsp_load  = (accept && !start) || ((state == S_DONE) && slot_free);
    sample    = pend && (state == S_SCAN);
    cnt_inc   = cnt + CNT_W'(1);
    cnt_dec   = cnt - CNT_W'(1);
    shift_dst = pend_idx - CNT_W'(1);
  end

  // Slot RAM port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cnt[ADDR_W-1:0];
    ram_wr_data = new_word;
    ram_rd_en   = 1'b0;
    case (state)
      S_IDLE: begin
        ram_wr_en = accept && (req.operation == OP_INSERT) && (cnt != CAP_CNT);
      end
      S_SCAN: begin
        ram_rd_en = (ptr != cnt);
      end
      S_SHIFT: begin
        // read slot i, write it to slot i-1 in the following cycle
        ram_rd_en   = (ptr != cnt);
        ram_wr_en   = pend;
        ram_wr_addr = shift_dst[ADDR_W-1:0];
        ram_wr_data = ram_rd_data;
      end
      default: begin
      end
    endcase
  end

  pqem_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ptr[ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  pqem_max_unit #(
    .CNT_W         (CNT_W),
    .PRIORITY_BITS (PRIORITY_BITS),
    .WORD_W        (WORD_W)
  ) u_max (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sample      (sample),
    .sample_idx  (pend_idx),
    .sample_word (ram_rd_data),
    .best_idx    (best_idx),
    .best_word   (best_word)
  );

  // Sequencer, count, read pointer and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      pend <= ram_rd_en;
      if (ram_rd_en) begin
        pend_idx <= ptr;
        ptr      <= ptr + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rsp.out_tag      <= '0;
            rsp.out_priority <= '0;
            if (req.operation == OP_INSERT) begin
              if (cnt == CAP_CNT) begin
                rsp.status    <= ST_FULL;
                rsp.occupancy <= to_occ(cnt);
              end else begin
                cnt           <= cnt_inc;
                rsp.status    <= ST_OK;
                rsp.occupancy <= to_occ(cnt_inc);
              end
            end else if (cnt == '0) begin
              rsp.status    <= ST_EMPTY;
              rsp.occupancy <= '0;
            end else begin
              ptr   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // all slots read and compared: close the gap behind the winner
          if ((ptr == cnt) && !pend) begin
            ptr   <= best_idx + CNT_W'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if ((ptr == cnt) && !pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            rsp.status       <= ST_OK;
            rsp.out_tag      <= tag_out_ext[TAG_FIELD_BITS-1:0];
            rsp.out_priority <= prio_out_ext[PRIO_FIELD_BITS-1:0];
            rsp.occupancy    <= to_occ(cnt_dec);
            cnt              <= cnt_dec;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/pqem_checker.sv =====
// ----------------------------------------------------------------------------
// pqem_checker
// Port-level checks for the extract-max priority queue, bound to the top.
// ----------------------------------------------------------------------------
module pqem_checker #(
  parameter int CAPACITY = pqem_pkg::DEF_CAPACITY
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input pqem_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input pqem_pkg::rsp_t rsp
);

  import pqem_pkg::*;

  localparam logic [OCC_BITS-1:0] CAP_OCC = OCC_BITS'(CAPACITY);

  // No response is pending right after reset
  a_rst_idle: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // A stalled response transaction holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // An insert transaction is answered on the next cycle
  a_insert_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.operation == OP_INSERT) |=> rsp_valid)
    else $error("insert not answered");

  // Empty extract returns nothing and reports an empty queue
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_EMPTY) |->
      (rsp.occupancy == '0) && (rsp.out_tag == '0) && (rsp.out_priority == '0))
    else $error("empty response carries data");

  // Full insert returns nothing and reports a full queue
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |->
      (rsp.occupancy == CAP_OCC) && (rsp.out_tag == '0) && (rsp.out_priority == '0))
    else $error("full response inconsistent");

endmodule

bind priority_queue_extract_max pqem_checker #(
  .CAPACITY (CAPACITY)
) u_pqem_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== tb/priority_queue_extract_max_test.sv =====
// ----------------------------------------------------------------------------
// priority_queue_extract_max_test
// Drives insert and extract transactions into the priority queue and checks
// every response against a behavioral copy of the queue kept in this bench.
// A short table covers empty and full, extreme tags and priorities, and
// ties. Random bursts that lean toward inserts or extracts follow, so the
// queue fills and drains many times. Both channels idle at random.
// ----------------------------------------------------------------------------
module priority_queue_extract_max_test;
  import pqem_pkg::*;

  localparam int CAP          = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 700;
  localparam int SETTLE       = 2 * CAP + 20;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  // Bench copy of the queue contents, oldest entry in slot 0
  logic [TAG_FIELD_BITS-1:0]  held_tag  [CAP];
  logic [PRIO_FIELD_BITS-1:0] held_prio [CAP];
  int                         held_count;

  rsp_t      owed_rsps [$];
  plan_row_t plan [$];
  int        mismatches;
  bit        steady;

  priority_queue_extract_max DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the bench queue and return the response it owes
  function automatic rsp_t pq_apply(input req_t r);
    rsp_t res;
    int   best;
    res = '0;
    res.status = ST_OK;
    if (r.operation == OP_INSERT) begin
      if (held_count >= CAP) begin
        res.status = ST_FULL;
      end else begin
        held_tag[held_count]  = r.entry_tag;
        held_prio[held_count] = r.entry_priority;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // strict compare keeps the oldest entry on equal priority
      best = 0;
      for (int i = 1; i < held_count; i++) begin
        if (held_prio[i] > held_prio[best]) best = i;
      end
      res.out_tag      = held_tag[best];
      res.out_priority = held_prio[best];
      for (int i = best; i < held_count - 1; i++) begin
        held_tag[i]  = held_tag[i + 1];
        held_prio[i] = held_prio[i + 1];
      end
      held_count--;
    end
    res.occupancy = OCC_BITS'(held_count);
    return res;
  endfunction

  function automatic plan_row_t row(input op_t op, input logic [31:0] tag,
                                    input logic [15:0] prio, input bit typed,
                                    input status_t st, input logic [31:0] otag,
                                    input logic [15:0] oprio, input int occ);
    plan_row_t p;
    p.req.operation      = op;
    p.req.entry_tag      = tag;
    p.req.entry_priority = prio;
    p.typed              = typed;
    p.want.status        = st;
    p.want.out_tag       = otag;
    p.want.out_priority  = oprio;
    p.want.occupancy     = OCC_BITS'(occ);
    return p;
  endfunction

  // Random request; priority mode picks between tie-heavy and wide values
  function automatic req_t random_request(input int insert_pct);
    req_t r;
    r.operation = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
    r.entry_tag = $urandom();
    case ($urandom_range(3))
      0: r.entry_priority = 16'($urandom_range(3));
      1: r.entry_priority = 16'hFFFF - 16'($urandom_range(2));
      default: r.entry_priority = 16'($urandom());
    endcase
    return r;
  endfunction

  // Present one request, with random gaps, and record what it owes
  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    rsp_t owed;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 15) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    owed = pq_apply(r);
    owed_rsps.push_back(typed ? want : owed);
  endtask

  // Hold the request side until every owed response is back
  task automatic drain;
    @(negedge clk);
    req_valid <= 1'b0;
    while (owed_rsps.size() != 0) @(negedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  // Response side stalls at random, except during the steady stretch
  always @(negedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= 15);
  end

  // Compare each response transaction with the oldest owed one
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (owed_rsps.size() == 0) begin
        note_mismatch("unexpected response", 32'd0, {30'd0, rsp.status});
      end else begin
        want = owed_rsps.pop_front();
        if (rsp.status != want.status)
          note_mismatch("status", 32'(want.status), 32'(rsp.status));
        if (rsp.out_tag != want.out_tag)
          note_mismatch("out_tag", want.out_tag, rsp.out_tag);
        if (rsp.out_priority != want.out_priority)
          note_mismatch("out_priority", 32'(want.out_priority),
                        32'(rsp.out_priority));
        if (rsp.occupancy != want.occupancy)
          note_mismatch("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("priority_queue_extract_max_test: errors");
    $finish;
  end

  initial begin
    int   insert_pct;
    int   burst_left;
    rsp_t none;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    rsp_ready  = 1'b0;
    steady     = 1'b0;
    mismatches = 0;
    held_count = 0;
    none       = '0;
    insert_pct = 50;
    burst_left = 0;

    // Directed table: empty, zero priority, fill with ties, full, then four extracts
    plan.push_back(row(OP_EXTRACT, 32'h0, 16'h0, 1, ST_EMPTY, 32'h0, 16'h0, 0));
    plan.push_back(row(OP_INSERT, 32'hFFFF_FFFF, 16'h0, 1, ST_OK, 32'h0, 16'h0, 1));
    plan.push_back(row(OP_EXTRACT, 32'h0, 16'h0, 1, ST_OK, 32'hFFFF_FFFF, 16'h0, 0));
    plan.push_back(row(OP_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF, 1,
                       ST_EMPTY, 32'h0, 16'h0, 0));
    plan.push_back(row(OP_INSERT, 32'h0, 16'h8000, 1, ST_OK, 32'h0, 16'h0, 1));
    plan.push_back(row(OP_INSERT, 32'hA5A5_A5A5, 16'hFFFF, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h5A5A_5A5A, 16'h0000, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_0003, 16'h8000, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_0004, 16'h0001, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_0005, 16'hFFFF, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h8000_0000, 16'h7FFF, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_0007, 16'h0000, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_0008, 16'h8000, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_0009, 16'h00FF, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_000A, 16'hFF00, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_000B, 16'h0002, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_000C, 16'hFFFE, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_000D, 16'h5555, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h0000_000E, 16'hAAAA, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 0, ST_OK, 0, 0, 0));
    plan.push_back(row(OP_INSERT, 32'h1234_5678, 16'hFFFF, 1,
                       ST_FULL, 32'h0, 16'h0, CAP));
    repeat (4) plan.push_back(row(OP_EXTRACT, 32'h0, 16'h0, 0, ST_OK, 0, 0, 0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue(plan[i].req, plan[i].typed, plan[i].want);
    drain();

    // Random bursts leaning toward inserts, extracts, or neither
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 250 && n < 400);
      if (n == 500) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 40);
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      issue(random_request(insert_pct), 1'b0, none);
    end
    steady = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;
    while (owed_rsps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("priority_queue_extract_max_test: clean");
    end else begin
      $display("priority_queue_extract_max_test: errors");
    end
    $finish;
  end

endmodule
